// ===== rtl/core/asx_pkg.sv =====
// Package for the ARM subset execute unit: beat types, field widths and codes.
// No dependencies.
`default_nettype none
package asx_pkg;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned RegIdxW = 4;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction;
    logic [31:0] read_data;
  } asx_in_t;

  typedef struct packed {
    logic [31:0] program_counter;
    logic        bus_valid;
    logic        bus_is_write;
    logic        bus_is_byte;
    logic [31:0] bus_address;
    logic [31:0] bus_write_data;
    logic [3:0]  flags_out;
    logic [1:0]  status;
  } asx_out_t;

  localparam logic       OpExec = 1'b0;
  localparam logic       OpLoad = 1'b1;
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StCond = 2'd1;
  localparam logic [1:0] StUnimp = 2'd2;

  localparam logic [3:0] AluAnd = 4'h0;
  localparam logic [3:0] AluEor = 4'h1;
  localparam logic [3:0] AluSub = 4'h2;
  localparam logic [3:0] AluAdd = 4'h4;
  localparam logic [3:0] AluCmp = 4'hA;
  localparam logic [3:0] AluOrr = 4'hC;
  localparam logic [3:0] AluMov = 4'hD;

  localparam logic [31:0] BxMask  = 32'h0FFF_FFF0;
  localparam logic [31:0] BxMatch = 32'h012F_FF10;
  localparam logic [3:0]  PcIdx   = 4'd15;
  localparam logic [3:0]  LrIdx   = 4'd14;

  function automatic logic cond_pass(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, c, v;
    n = f[3]; z = f[2]; c = f[1]; v = f[0];
    case (cc)
      4'h0: cond_pass = z;
      4'h1: cond_pass = !z;
      4'h2: cond_pass = c;
      4'h3: cond_pass = !c;
      4'h4: cond_pass = n;
      4'h5: cond_pass = !n;
      4'h6: cond_pass = v;
      4'h7: cond_pass = !v;
      4'h8: cond_pass = c && !z;
      4'h9: cond_pass = !c || z;
      4'hA: cond_pass = n == v;
      4'hB: cond_pass = n != v;
      4'hC: cond_pass = !z && (n == v);
      4'hD: cond_pass = z || (n != v);
      default: cond_pass = 1'b1;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/asx_regfile.sv =====
// Register file of the ARM subset execute unit: 16x32 RAM, 3 read ports, 2 write ports.
// The PC is kept outside. Depends on asx_pkg.
`default_nettype none
module asx_regfile import asx_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               re_i,
  input  wire logic [RegIdxW-1:0] ra_i,
  input  wire logic [RegIdxW-1:0] rb_i,
  input  wire logic [RegIdxW-1:0] rc_i,
  output logic      [31:0]        ra_o,
  output logic      [31:0]        rb_o,
  output logic      [31:0]        rc_o,
  input  wire logic               we0_i,
  input  wire logic [RegIdxW-1:0] wa0_i,
  input  wire logic [31:0]        wd0_i,
  input  wire logic               we1_i,
  input  wire logic [RegIdxW-1:0] wa1_i,
  input  wire logic [31:0]        wd1_i
);
  logic [31:0] mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [RegIdxW-1:0] ra_q, rb_q, rc_q;
  logic [31:0] da_q, db_q, dc_q;

  // valid bits stand in for the reset value of every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (we0_i) vld_q[wa0_i] <= 1'b1;
      if (we1_i) vld_q[wa1_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0_i) mem_q[wa0_i] <= wd0_i;
    if (we1_i) mem_q[wa1_i] <= wd1_i;
    if (re_i) begin
      ra_q <= ra_i; rb_q <= rb_i; rc_q <= rc_i;
      da_q <= mem_q[ra_i]; db_q <= mem_q[rb_i]; dc_q <= mem_q[rc_i];
    end
  end

  logic [NumRegs-1:0] vld_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_rd_q <= '0;
    else if (re_i) vld_rd_q <= vld_q;
  end

  assign ra_o = vld_rd_q[ra_q] ? da_q : '0;
  assign rb_o = vld_rd_q[rb_q] ? db_q : '0;
  assign rc_o = vld_rd_q[rc_q] ? dc_q : '0;
endmodule
`default_nettype wire

// ===== rtl/core/arm_subset_execute_unit.sv =====
// Top level of the ARM subset execute unit: decode, ALU, forwarding, output stage.
// Depends on asx_pkg and asx_regfile.
//
// Usage: in_valid_i/in_stall_o carry one beat per instruction word (operation 0)
// or per load-data return (operation 1). Each beat yields exactly one result beat
// on out_valid_o/out_stall_i with r15, the bus request, NZCV and a status code.
// A beat is accepted into a register-read stage (synchronous RAM of r0..r14),
// executes in the next cycle and lands in the output register, which drives
// out_valid_o. One beat per cycle is sustained while the receiver does not stall;
// the rate is set by the single read-modify-write pass over the register RAM,
// with writes of the executing beat forwarded to the reading one.
// r15, flags and the pending-load state live in flip-flops.
// Reset clears all registers to zero (through per-entry valid bits) and empties
// the pipeline. When the receiver stalls, the output register holds; the execute
// stage then holds too and the input stalls once both are full.
`default_nettype none
module arm_subset_execute_unit import asx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire asx_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output asx_out_t      out_data_o
);
  logic     ex_vld_q, out_vld_q;
  asx_in_t  ex_q;
  asx_out_t out_q;
  logic     ex_go, in_go;

  assign ex_go      = ex_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = ex_vld_q && !ex_go;
  assign in_go      = in_valid_i && !in_stall_o;

  logic [31:0] pc_q, pc_d;
  logic [3:0]  fl_q, fl_d;
  logic        lp_q, lp_d;
  logic [3:0]  lt_q, lt_d;

  logic [31:0] w;
  assign w = in_data_i.instruction;

  // RAM write ports (r0..r14 only; r15 held in pc_q)
  logic        we0, we1;
  logic [3:0]  wa0, wa1;
  logic [31:0] wd0, wd1;
  logic [31:0] ra_m, rb_m, rc_m;

  asx_regfile u_rf (
    .clk_i, .rst_ni, .re_i(in_go),
    .ra_i(w[19:16]), .rb_i(w[3:0]), .rc_i(w[15:12]),
    .ra_o(ra_m), .rb_o(rb_m), .rc_o(rc_m),
    .we0_i(we0), .wa0_i(wa0), .wd0_i(wd0),
    .we1_i(we1), .wa1_i(wa1), .wd1_i(wd1)
  );

  // forwarding of the previous executed beat's writes
  logic        fw0_q, fw1_q;
  logic [3:0]  fa0_q, fa1_q;
  logic [31:0] fd0_q, fd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw0_q <= 1'b0; fw1_q <= 1'b0;
    end else if (in_go || ex_go) begin
      fw0_q <= in_go && ex_go && we0;
      fw1_q <= in_go && ex_go && we1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ex_go) begin
      fa0_q <= wa0; fd0_q <= wd0; fa1_q <= wa1; fd1_q <= wd1;
    end
  end

  function automatic logic [31:0] fwd(input logic [3:0] a, input logic [31:0] m,
                                      input logic [31:0] pc, input logic e0,
                                      input logic [3:0] a0, input logic [31:0] d0,
                                      input logic e1, input logic [3:0] a1,
                                      input logic [31:0] d1);
    if (a == PcIdx) fwd = pc;
    else if (e1 && a1 == a) fwd = d1;
    else if (e0 && a0 == a) fwd = d0;
    else fwd = m;
  endfunction

  logic [31:0] rn_v, rm_v, rd_v;
  logic [31:0] x;
  assign x    = ex_q.instruction;
  assign rn_v = fwd(x[19:16], ra_m, pc_q, fw0_q, fa0_q, fd0_q, fw1_q, fa1_q, fd1_q);
  assign rm_v = fwd(x[3:0],   rb_m, pc_q, fw0_q, fa0_q, fd0_q, fw1_q, fa1_q, fd1_q);
  assign rd_v = fwd(x[15:12], rc_m, pc_q, fw0_q, fa0_q, fd0_q, fw1_q, fa1_q, fd1_q);

  asx_out_t    res;
  logic [31:0] op2, alu, moved, imm32, pc4;
  logic [4:0]  rot;
  logic [32:0] sub33, add33;
  logic        wr_rd, wr15;

  always_comb begin
    rot   = {x[11:8], 1'b0};
    imm32 = ({24'd0, x[7:0]} >> rot) | ({24'd0, x[7:0]} << (6'd32 - {1'b0, rot}));
    op2   = x[25] ? imm32 : rm_v;
    sub33 = {1'b0, rn_v} - {1'b0, op2};
    add33 = {1'b0, rn_v} + {1'b0, op2};
    moved = x[23] ? rn_v + {20'd0, x[11:0]} : rn_v - {20'd0, x[11:0]};
    pc4   = pc_q + 32'd4;
    alu   = '0;

    res   = '0;
    pc_d  = pc_q; fl_d = fl_q; lp_d = lp_q; lt_d = lt_q;
    we0   = 1'b0; wa0 = '0; wd0 = '0;
    we1   = 1'b0; wa1 = '0; wd1 = '0;
    wr_rd = 1'b0; wr15 = 1'b0;

    if (ex_q.operation == OpLoad) begin
      if (lp_q) begin
        lp_d = 1'b0;
        if (lt_q == PcIdx) pc_d = ex_q.read_data + 32'd4;
        else begin
          we0 = 1'b1; wa0 = lt_q; wd0 = ex_q.read_data;
        end
      end else res.status = StUnimp;
    end else if (!cond_pass(x[31:28], fl_q)) begin
      pc_d = pc4; res.status = StCond;
    end else if (x[27:25] == 3'b101) begin
      if (x[24]) begin
        we0 = 1'b1; wa0 = LrIdx; wd0 = pc4;
      end
      pc_d = pc_q + 32'd8 + {{6{x[23]}}, x[23:0], 2'b00};
    end else if ((x & BxMask) == BxMatch) begin
      pc_d = rm_v;
    end else if (x[27:26] == 2'b00) begin
      wr_rd = 1'b1;
      case (x[24:21]) inside
        AluAnd: alu = rn_v & op2;
        AluEor: alu = rn_v ^ op2;
        AluOrr: alu = rn_v | op2;
        AluMov: alu = op2;
        AluSub, AluCmp: alu = sub33[31:0];
        AluAdd: alu = add33[31:0];
        default: begin
          wr_rd = 1'b0; res.status = StUnimp;
        end
      endcase
      if (x[24:21] == AluCmp) wr_rd = 1'b0;
      if (wr_rd || x[24:21] == AluCmp) begin
        if (x[20] || x[24:21] == AluCmp) begin
          fl_d[3] = alu[31];
          fl_d[2] = alu == 32'd0;
          if (x[24:21] == AluSub || x[24:21] == AluCmp) begin
            fl_d[1] = !sub33[32];
            fl_d[0] = (rn_v[31] ^ op2[31]) & (rn_v[31] ^ alu[31]);
          end else if (x[24:21] == AluAdd) begin
            fl_d[1] = add33[32];
            fl_d[0] = (rn_v[31] ^ alu[31]) & (op2[31] ^ alu[31]);
          end
        end
      end
      pc_d = pc4;
      if (wr_rd) begin
        if (x[15:12] == PcIdx) pc_d = alu + 32'd4;
        else begin
          we0 = 1'b1; wa0 = x[15:12]; wd0 = alu;
        end
      end
    end else if (x[27:26] == 2'b01 && !x[25]) begin
      res.bus_valid   = 1'b1;
      res.bus_is_byte = x[22];
      res.bus_address = x[24] ? moved : rn_v;
      pc_d = pc4;
      if (!x[24] || x[21]) begin
        if (x[19:16] == PcIdx) wr15 = 1'b1;
        else begin
          we1 = 1'b1; wa1 = x[19:16]; wd1 = moved;
        end
      end
      if (wr15) pc_d = moved + 32'd4;
      if (x[20]) begin
        lp_d = 1'b1; lt_d = x[15:12];
      end else begin
        res.bus_is_write   = 1'b1;
        res.bus_write_data = x[22] ? {24'd0, rd_v[7:0]} : rd_v;
      end
    end else begin
      pc_d = pc4; res.status = StUnimp;
    end
    res.program_counter = pc_d;
    res.flags_out       = fl_d;
    if (!ex_go) begin
      we0 = 1'b0; we1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0; out_vld_q <= 1'b0;
      pc_q <= '0; fl_q <= '0; lp_q <= 1'b0; lt_q <= '0;
    end else begin
      if (in_go) ex_vld_q <= 1'b1;
      else if (ex_go) ex_vld_q <= 1'b0;
      if (ex_go) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
      if (ex_go) begin
        pc_q <= pc_d; fl_q <= fl_d; lp_q <= lp_d; lt_q <= lt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) ex_q <= in_data_i;
    if (ex_go) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ===== tb/sv/arm_subset_execute_unit_tb.sv =====
// Testbench for arm_subset_execute_unit: directed table plus random instruction mix,
// checked beat by beat against a behavioral model of the execute unit.
// Depends on asx_pkg and the execute unit RTL.
`default_nettype none
module arm_subset_execute_unit_tb;
  import asx_pkg::*;

  localparam int unsigned NumRandom = 750;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [31:0] CondAl = 32'hE000_0000;

  typedef struct {
    asx_in_t  stim;
    logic     typed;
    asx_out_t want;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  asx_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  asx_out_t out_data_o;

  logic [31:0] regs [16];
  logic [3:0]  nzcv;
  logic        ld_busy;
  logic [3:0]  ld_dest;
  asx_out_t    pending_q [$];
  int          fails = 0;
  int          cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_long = 1'b0;
  logic        done = 1'b0;
  row_t        rows [$];

  arm_subset_execute_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic cc_ok(input logic [3:0] cc);
    logic n, z, c, v;
    n = nzcv[3]; z = nzcv[2]; c = nzcv[1]; v = nzcv[0];
    case (cc)
      4'h0: return z;
      4'h1: return !z;
      4'h2: return c;
      4'h3: return !c;
      4'h4: return n;
      4'h5: return !n;
      4'h6: return v;
      4'h7: return !v;
      4'h8: return c && !z;
      4'h9: return !c || z;
      4'hA: return n == v;
      4'hB: return n != v;
      4'hC: return !z && (n == v);
      4'hD: return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  function automatic void set_nz(input logic [31:0] r);
    nzcv[3] = r[31];
    nzcv[2] = (r == 32'd0);
  endfunction

  function automatic asx_out_t execute_beat(input asx_in_t b);
    asx_out_t o;
    logic [31:0] w, a, op2, res, base, moved, imm;
    logic [3:0] opc, rd, rn;
    logic [4:0] rot;
    o = '0;
    o.status = StOk;
    w = b.instruction;
    if (b.operation == OpLoad) begin
      if (ld_busy) begin
        regs[ld_dest] = (ld_dest == PcIdx) ? b.read_data + 32'd4 : b.read_data;
        ld_busy = 1'b0;
      end else begin
        o.status = StUnimp;
      end
    end else if (!cc_ok(w[31:28])) begin
      regs[PcIdx] += 32'd4;
      o.status = StCond;
    end else if (w[27:25] == 3'b101) begin
      imm = {{8{w[23]}}, w[23:0]};
      if (w[24]) regs[LrIdx] = regs[PcIdx] + 32'd4;
      regs[PcIdx] = regs[PcIdx] + 32'd8 + (imm << 2);
    end else if ((w & BxMask) == BxMatch) begin
      regs[PcIdx] = regs[w[3:0]];
    end else if (w[27:26] == 2'b00) begin
      opc = w[24:21];
      rd = w[15:12];
      a = regs[w[19:16]];
      if (w[25]) begin
        rot = {w[11:8], 1'b0};
        op2 = ({24'd0, w[7:0]} >> rot) | ({24'd0, w[7:0]} << (6'd32 - rot));
        if (rot == 0) op2 = {24'd0, w[7:0]};
      end else begin
        op2 = regs[w[3:0]];
      end
      res = '0;
      case (opc)
        AluAnd, AluEor, AluOrr, AluMov: begin
          res = (opc == AluAnd) ? a & op2 : (opc == AluEor) ? a ^ op2 :
                (opc == AluOrr) ? a | op2 : op2;
          if (w[20]) set_nz(res);
          regs[rd] = res;
        end
        AluSub, AluCmp: begin
          res = a - op2;
          if (w[20] || opc == AluCmp) begin
            set_nz(res);
            nzcv[1] = (a >= op2);
            nzcv[0] = (a[31] ^ op2[31]) & (a[31] ^ res[31]);
          end
          if (opc == AluSub) regs[rd] = res;
        end
        AluAdd: begin
          res = a + op2;
          if (w[20]) begin
            set_nz(res);
            nzcv[1] = (res < a);
            nzcv[0] = (a[31] ^ res[31]) & (op2[31] ^ res[31]);
          end
          regs[rd] = res;
        end
        default: o.status = StUnimp;
      endcase
      regs[PcIdx] += 32'd4;
    end else if (w[27:26] == 2'b01 && !w[25]) begin
      rn = w[19:16];
      rd = w[15:12];
      base = regs[rn];
      moved = w[23] ? base + {20'd0, w[11:0]} : base - {20'd0, w[11:0]};
      o.bus_valid = 1'b1;
      o.bus_is_byte = w[22];
      o.bus_address = w[24] ? moved : base;
      if (w[20]) begin
        if (!w[24] || w[21]) regs[rn] = moved;
        ld_busy = 1'b1;
        ld_dest = rd;
      end else begin
        o.bus_is_write = 1'b1;
        o.bus_write_data = w[22] ? {24'd0, regs[rd][7:0]} : regs[rd];
        if (!w[24] || w[21]) regs[rn] = moved;
      end
      regs[PcIdx] += 32'd4;
    end else begin
      regs[PcIdx] += 32'd4;
      o.status = StUnimp;
    end
    o.program_counter = regs[PcIdx];
    o.flags_out = nzcv;
    return o;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 3) != 0) w[31:28] = 4'hE;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w[27:26] = 2'b00;
        w[24:21] = AluMov;
        case ($urandom_range(0, 6))
          0: w[24:21] = AluAnd;
          1: w[24:21] = AluEor;
          2: w[24:21] = AluSub;
          3: w[24:21] = AluAdd;
          4: w[24:21] = AluCmp;
          5: w[24:21] = AluOrr;
          default: w[24:21] = 4'($urandom_range(0, 15));
        endcase
        if ($urandom_range(0, 7) == 0) w[15:12] = PcIdx;
      end
      3, 4, 5: begin
        w[27:25] = 3'b010;
        if ($urandom_range(0, 1)) w[11:0] = 12'($urandom_range(0, 15));
      end
      6: w[27:25] = 3'b101;
      7: w = {w[31:28], BxMatch[27:4], w[3:0]};
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(input logic op, input logic [31:0] w, input logic [31:0] d,
                         input logic typed, input asx_out_t want);
    row_t r;
    r.stim = '{operation: op, instruction: w, read_data: d};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic send_beat(input asx_in_t b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(execute_beat(b));
    @(negedge clk_i);
  endtask

  initial begin
    asx_out_t exp_o;
    asx_in_t  b;
    int       k;
    for (k = 0; k < 16; k++) regs[k] = '0;
    nzcv = '0;
    ld_busy = 1'b0;
    ld_dest = '0;
    exp_o = '0;
    exp_o.status = StUnimp;
    add_row(OpLoad, 32'h0, 32'hFFFF_FFFF, 1'b1, exp_o);
    exp_o.status = StOk;
    exp_o.program_counter = 32'd4;
    exp_o.flags_out = 4'b0100;
    add_row(OpExec, 32'hE3B0_0000, 32'h0, 1'b1, exp_o);
    exp_o.program_counter = 32'd8;
    exp_o.status = StCond;
    add_row(OpExec, 32'h13A0_10FF, 32'h0, 1'b1, exp_o);
    add_row(OpExec, 32'hE3E0_0000 | 32'h0000_00FF, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE3A0_14FF, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE091_2001, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE051_3000, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE35_10000 | 32'h0000_0001, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE021_4002, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE181_5002, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE001_6002, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE1E0_0000, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE7F1_0FFF, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE5A1_1FFF, 0, 1'b0, exp_o);
    add_row(OpLoad, 0, 32'h8000_0001, 1'b0, exp_o);
    add_row(OpExec, 32'hE4C1_2001, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE591_F000, 0, 1'b0, exp_o);
    add_row(OpLoad, 0, 32'h0000_0100, 1'b0, exp_o);
    add_row(OpExec, 32'hEB7F_FFFF, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hFA80_0000, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE12F_FF1E, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hE3A0_FF40, 0, 1'b0, exp_o);
    add_row(OpExec, 32'hEE00_0000, 0, 1'b0, exp_o);
    add_row(OpExec, 32'h0000_0000, 0, 1'b0, exp_o);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) begin
      send_beat(rows[i].stim);
      if (rows[i].typed) pending_q[pending_q.size() - 1] = rows[i].want;
    end
    hold_long <= 1'b1;
    for (k = 0; k < NumRandom; k++) begin
      if (k == 60) hold_long <= 1'b0;
      if (k == NumRandom - 100) quiet = 1'b1;
      b.operation = ($urandom_range(0, 4) == 0) ? OpLoad : OpExec;
      b.instruction = random_word();
      b.read_data = $urandom;
      send_beat(b);
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    done = 1'b1;
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (200) @(negedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_long);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    asx_out_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.program_counter !== e.program_counter) begin
          $error("program_counter exp %h got %h", e.program_counter, out_data_o.program_counter);
          fails++;
        end
        if (out_data_o.bus_valid !== e.bus_valid) begin
          $error("bus_valid exp %h got %h", e.bus_valid, out_data_o.bus_valid);
          fails++;
        end
        if (out_data_o.bus_is_write !== e.bus_is_write) begin
          $error("bus_is_write exp %h got %h", e.bus_is_write, out_data_o.bus_is_write);
          fails++;
        end
        if (out_data_o.bus_is_byte !== e.bus_is_byte) begin
          $error("bus_is_byte exp %h got %h", e.bus_is_byte, out_data_o.bus_is_byte);
          fails++;
        end
        if (out_data_o.bus_address !== e.bus_address) begin
          $error("bus_address exp %h got %h", e.bus_address, out_data_o.bus_address);
          fails++;
        end
        if (out_data_o.bus_write_data !== e.bus_write_data) begin
          $error("bus_write_data exp %h got %h", e.bus_write_data, out_data_o.bus_write_data);
          fails++;
        end
        if (out_data_o.flags_out !== e.flags_out) begin
          $error("flags_out exp %h got %h", e.flags_out, out_data_o.flags_out);
          fails++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status exp %h got %h", e.status, out_data_o.status);
          fails++;
        end
      end
    end
  end

  initial begin
    while (!done && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (done && fails == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
